// ===== rtl/ehp_pkg.sv =====
// Shared types, constants and the ethertype classifier for the Ethernet header parser.
// No dependencies; every other RTL file of the parser refers to this package by scoped names.
package ehp_pkg;

    // Header byte offsets, counted from the first byte of the packet.
    localparam logic [4:0] POS_SRC    = 5'd6;
    localparam logic [4:0] POS_TYPE   = 5'd12;
    localparam logic [4:0] POS_TYPE_LO = 5'd13;
    localparam logic [4:0] POS_TAG    = 5'd14;
    localparam logic [4:0] POS_INNER_LO = 5'd17;
    localparam logic [4:0] POS_MAX    = 5'd31;

    // Header lengths, type values and class codes.
    localparam logic [4:0]  PLAIN_LEN    = 5'd14;
    localparam logic [4:0]  TAGGED_LEN   = 5'd18;
    localparam logic [15:0] LENGTH_LIMIT = 16'd1500;
    localparam logic [15:0] TAG_TYPE     = 16'h8100;
    localparam logic [4:0]  CODE_UNKNOWN = 5'd22;
    localparam int          TABLE_SIZE   = 21;

    // Depth of the queue between front and back, and its index widths.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Packed widths of the result word.
    localparam int OUT_DATA_W = 144;

    // Known ethertypes; the position in this table is the class code.
    localparam logic [15:0] KNOWN_TYPES [TABLE_SIZE] = '{
        16'h00bb, 16'h0200, 16'h0800, 16'h0806, 16'h88a2, 16'h2000, 16'h2004,
        16'h8035, 16'h8100, 16'h88a8, 16'h9100, 16'h9200, 16'h8137, 16'h86DD,
        16'h880B, 16'h8847, 16'h8848, 16'h8863, 16'h8864, 16'h88CC, 16'h6558
    };

    // Header record passed from the front to the back through the queue.
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic        has_vlan;
        logic [15:0] vlan_tag;
        logic [15:0] type_value;
        logic        too_short;
    } t_hdr_rec;

    // Class code of a type value; the lowest matching entry wins.
    function automatic logic [4:0] classify(input logic [15:0] value);
        logic [4:0] code;
        code = CODE_UNKNOWN;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (KNOWN_TYPES[i] == value) begin
                code = 5'(i);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/ehp_front.sv =====
// Front end of the Ethernet header parser: takes packet bytes and captures header fields.
// Depends on ehp_pkg for offsets, constants and the header record type.
module ehp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_push,
    output ehp_pkg::t_hdr_rec o_rec
);

    logic [4:0]  r_pos, n_pos;
    logic        r_done, n_done;
    logic [47:0] r_dst, n_dst;
    logic [47:0] r_src, n_src;
    logic [15:0] r_outer, n_outer;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_inner, n_inner;
    logic        complete;
    logic        is_tagged;

    // Shift each byte into the field that its offset selects.
    always_comb begin
        n_pos    = r_pos;
        n_done   = r_done;
        n_dst    = r_dst;
        n_src    = r_src;
        n_outer  = r_outer;
        n_tag    = r_tag;
        n_inner  = r_inner;
        complete = 1'b0;
        if (i_accept) begin
            if (!r_done) begin
                if (r_pos < ehp_pkg::POS_SRC) begin
                    n_dst = {r_dst[39:0], i_byte};
                end else if (r_pos < ehp_pkg::POS_TYPE) begin
                    n_src = {r_src[39:0], i_byte};
                end else if (r_pos < ehp_pkg::POS_TAG) begin
                    n_outer = {r_outer[7:0], i_byte};
                    if (r_pos == ehp_pkg::POS_TYPE_LO && n_outer != ehp_pkg::TAG_TYPE) begin
                        complete = 1'b1;
                    end
                end else if (r_pos < ehp_pkg::POS_TAG + 5'd2) begin
                    n_tag = {r_tag[7:0], i_byte};
                end else begin
                    n_inner = {r_inner[7:0], i_byte};
                    if (r_pos >= ehp_pkg::POS_INNER_LO) begin
                        complete = 1'b1;
                    end
                end
                if (r_pos != ehp_pkg::POS_MAX) begin
                    n_pos = r_pos + 5'd1;
                end
                if (complete) begin
                    n_done = 1'b1;
                end
            end
            // The end of a packet always rearms the parser.
            if (i_last) begin
                n_pos  = '0;
                n_done = 1'b0;
            end
        end
    end

    // A record is due when the header completes or the packet ends early.
    assign is_tagged = (n_outer == ehp_pkg::TAG_TYPE);
    assign o_push    = i_accept && !r_done && (complete || i_last);

    always_comb begin
        o_rec.dst_mac    = n_dst;
        o_rec.src_mac    = n_src;
        o_rec.has_vlan   = is_tagged;
        o_rec.vlan_tag   = is_tagged ? n_tag : 16'd0;
        o_rec.type_value = is_tagged ? n_inner : n_outer;
        o_rec.too_short  = !complete;
    end

    // Control state is reset; captured fields are always overwritten before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_done <= n_done;
        end
        r_dst   <= n_dst;
        r_src   <= n_src;
        r_outer <= n_outer;
        r_tag   <= n_tag;
        r_inner <= n_inner;
    end

endmodule

// ===== rtl/ehp_queue.sv =====
// Short queue of header records between the front and back of the header parser.
// Depends on ehp_pkg for the record type and the queue depth.
module ehp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ehp_pkg::t_hdr_rec i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ehp_pkg::t_hdr_rec o_rec
);

    ehp_pkg::t_hdr_rec                r_mem [ehp_pkg::QUEUE_DEPTH];
    logic [ehp_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [ehp_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [ehp_pkg::QCNT_W-1:0]       r_count, n_count;
    logic                             do_push;
    logic                             do_pop;

    localparam logic [ehp_pkg::QPTR_W-1:0] LAST_PTR = ehp_pkg::QPTR_W'(ehp_pkg::QUEUE_DEPTH - 1);
    localparam logic [ehp_pkg::QCNT_W-1:0] FULL_CNT = ehp_pkg::QCNT_W'(ehp_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== rtl/ehp_back.sv =====
// Back end of the header parser: classifies queued headers and holds the result word.
// Depends on ehp_pkg for the record type, constants and the ethertype classifier.
module ehp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ehp_pkg::t_hdr_rec              i_rec,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ehp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [0:0]                     o_m_tuser
);

    logic                           r_valid;
    logic [ehp_pkg::OUT_DATA_W-1:0] r_data, n_data;
    logic                           r_short;
    logic                           is_len;
    logic [4:0]                     code;
    logic [4:0]                     hlen;

    // The output register takes a new record whenever it is empty or being emptied.
    assign o_pop = i_valid && (!r_valid || i_m_tready);

    // Classify the type value and pack the result word.
    always_comb begin
        is_len = (i_rec.type_value < ehp_pkg::LENGTH_LIMIT);
        code   = is_len ? ehp_pkg::CODE_UNKNOWN : ehp_pkg::classify(i_rec.type_value);
        hlen   = i_rec.has_vlan ? ehp_pkg::TAGGED_LEN : ehp_pkg::PLAIN_LEN;
        if (i_rec.too_short) begin
            n_data = {4'd0, ehp_pkg::PLAIN_LEN, ehp_pkg::CODE_UNKNOWN, 1'b0, 16'd0, 16'd0,
                      1'b0, 48'd0, 48'd0};
        end else begin
            n_data = {4'd0, hlen, code, is_len, i_rec.type_value, i_rec.vlan_tag,
                      i_rec.has_vlan, i_rec.src_mac, i_rec.dst_mac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_data  <= n_data;
            r_short <= i_rec.too_short;
        end
    end

    assign o_m_tvalid   = r_valid;
    assign o_m_tdata    = r_data;
    assign o_m_tuser[0] = r_short;

endmodule

// ===== rtl/ethernet_header_parser.sv =====
// Top level of the Ethernet II header parser with 802.1Q tag support.
// Instantiates ehp_front, ehp_queue and ehp_back; uses ehp_pkg.
//
// Usage:
//   Packet bytes enter on the slave stream, one word per byte, header first, with
//   tlast on the final byte. One result word leaves on the master stream for each
//   packet: when its 14-byte (or 18-byte tagged) header completes, or a too-short
//   result when the packet ends first. Later bytes of a packet are consumed silently.
//   Throughput is one byte per cycle, sustained; the front takes a byte every cycle
//   while the two-entry header queue has room.
//   A header record that completes is registered first in the queue, then, once
//   classified, in the output register that drives o_m_tvalid.
//   When the receiver stalls, the result holds in the output register, up to two more
//   headers wait in the queue, and o_s_tready falls only once the queue is full.
//   A synchronous active-low reset empties the queue and the output register and
//   rearms the parser for the start of a packet; no clearing pass is needed.
module ethernet_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tlast,   // last_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [47:0] dst_mac, [95:48] src_mac, [96] has_vlan, [112:97] vlan_tag,
    // [128:113] type_or_length, [129] is_length, [134:130] type_code,
    // [139:135] header_length, [143:140] zero
    output logic [143:0] o_m_tdata,
    output logic [0:0]   o_m_tuser    // [0] too_short
);

    logic              accept;
    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    ehp_pkg::t_hdr_rec front_rec;
    ehp_pkg::t_hdr_rec q_rec;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Byte capture and header detection.
    ehp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    // Decoupling queue of completed headers.
    ehp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // Classification and output register.
    ehp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_rec      (q_rec),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== rtl/ehp_checker.sv =====
// Port-level checks for the Ethernet header parser, attached by the bind below.
// Depends on ehp_pkg for header lengths and class codes.
module ehp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [143:0] o_m_tdata,
    input logic [0:0]   o_m_tuser
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A too-short result carries the plain length, the unknown class and no addresses.
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            o_m_tdata[139:135] == ehp_pkg::PLAIN_LEN &&
            o_m_tdata[134:130] == ehp_pkg::CODE_UNKNOWN &&
            o_m_tdata[129:0] == 130'd0)
        else $error("malformed too-short result");

    // Header length follows the tag flag on complete headers.
    a_hlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |->
            o_m_tdata[139:135] == (o_m_tdata[96] ? ehp_pkg::TAGGED_LEN : ehp_pkg::PLAIN_LEN))
        else $error("header length disagrees with tag flag");

    // A length frame is never classified.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[129] |-> o_m_tdata[134:130] == ehp_pkg::CODE_UNKNOWN)
        else $error("length frame given a type class");

endmodule

bind ethernet_header_parser ehp_checker u_ehp_checker (.*);

// ===== sim/tb_ethernet_header_parser.sv =====
// Self-checking testbench for ethernet_header_parser: byte streams in, one header word out.
// Depends on ehp_pkg and the parser RTL; predicts every result word and checks it field by field.
`timescale 1ns / 1ps

module tb_ethernet_header_parser;

    import ehp_pkg::*;

    // Cycles without any accepted word before the run is abandoned. The slowest
    // legal stretch is a heavy sender gap overlapping a heavy receiver stall,
    // so this leaves a wide margin.
    localparam int STALL_LIMIT = 1000;

    // Byte offset of the first inner type byte of a tagged header.
    localparam logic [4:0] POS_INNER = 5'd16;

    // Known ethertypes, highest class code first; the index is the class code.
    localparam logic [TABLE_SIZE-1:0][15:0] KNOWN_ETHERTYPES = {
        16'h6558, 16'h88CC, 16'h8864, 16'h8863, 16'h8848, 16'h8847, 16'h880B,
        16'h86DD, 16'h8137, 16'h9200, 16'h9100, 16'h88a8, 16'h8100, 16'h8035,
        16'h2004, 16'h2000, 16'h88a2, 16'h0806, 16'h0800, 16'h0200, 16'h00bb
    };

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } t_idle_mode;

    // One parsed header as it leaves the block.
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic        has_vlan;
        logic [15:0] vlan_tag;
        logic [15:0] type_len;
        logic        is_length;
        logic [4:0]  type_code;
        logic [4:0]  hdr_len;
        logic        too_short;
    } t_hdr_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata;   // [7:0] data_byte
    logic         i_s_tlast;   // last_byte
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // [47:0] dst_mac, [95:48] src_mac, [96] has_vlan, [112:97] vlan_tag,
    // [128:113] type_or_length, [129] is_length, [134:130] type_code,
    // [139:135] header_length, [143:140] zero
    logic [143:0] o_m_tdata;
    logic [0:0]   o_m_tuser;   // [0] too_short

    // Parser state mirrored by the predictor.
    logic [4:0]   byte_pos;
    logic [47:0]  dst_acc;
    logic [47:0]  src_acc;
    logic [15:0]  outer_type;
    logic [15:0]  tag_acc;
    logic [15:0]  inner_type;
    logic         hdr_done;

    t_hdr_result  hdr_expect[$];
    logic [7:0]   frame_q[$];
    int           mismatches = 0;
    int           sent_bytes = 0;
    int           burst_left = 0;
    int           rx_hold = 0;
    int           quiet_cycles = 0;
    t_idle_mode   tx_mode = IDLE_LIGHT;
    t_idle_mode   rx_mode = IDLE_LIGHT;

    ethernet_header_parser DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Class code of a type value, or unknown when it is not in the table.
    function automatic logic [4:0] ethertype_class(input logic [15:0] value);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (KNOWN_ETHERTYPES[i] == value) begin
                return 5'(i);
            end
        end
        return CODE_UNKNOWN;
    endfunction

    function automatic void clear_parse_state();
        byte_pos   = '0;
        dst_acc    = '0;
        src_acc    = '0;
        outer_type = '0;
        tag_acc    = '0;
        inner_type = '0;
        hdr_done   = 1'b0;
    endfunction

    // Advances the predicted parser by one accepted byte and queues any result it causes.
    function automatic void parse_byte(input logic [7:0] value, input logic last);
        t_hdr_result res;
        logic        complete;
        logic        is_tagged;
        complete = 1'b0;
        sent_bytes++;
        if (!hdr_done) begin
            if (byte_pos < POS_SRC) begin
                dst_acc = {dst_acc[39:0], value};
            end else if (byte_pos < POS_TYPE) begin
                src_acc = {src_acc[39:0], value};
            end else if (byte_pos < POS_TAG) begin
                outer_type = {outer_type[7:0], value};
                complete = (byte_pos == POS_TYPE_LO) && (outer_type != TAG_TYPE);
            end else if (byte_pos < POS_INNER) begin
                tag_acc = {tag_acc[7:0], value};
            end else begin
                inner_type = {inner_type[7:0], value};
                complete = (byte_pos >= POS_INNER_LO);
            end
            if (byte_pos < POS_MAX) begin
                byte_pos++;
            end

            if (complete) begin
                is_tagged     = (outer_type == TAG_TYPE);
                res.dst_mac   = dst_acc;
                res.src_mac   = src_acc;
                res.has_vlan  = is_tagged;
                res.vlan_tag  = is_tagged ? tag_acc : 16'h0000;
                res.type_len  = is_tagged ? inner_type : outer_type;
                res.is_length = (res.type_len < LENGTH_LIMIT);
                res.type_code = res.is_length ? CODE_UNKNOWN : ethertype_class(res.type_len);
                res.hdr_len   = is_tagged ? TAGGED_LEN : PLAIN_LEN;
                res.too_short = 1'b0;
                hdr_expect.push_back(res);
                hdr_done = 1'b1;
            end else if (last) begin
                res           = '0;
                res.type_code = CODE_UNKNOWN;
                res.hdr_len   = PLAIN_LEN;
                res.too_short = 1'b1;
                hdr_expect.push_back(res);
            end
        end
        // Every packet boundary rearms the parser.
        if (last) begin
            clear_parse_state();
        end
    endfunction

    function automatic logic [47:0] rand_mac();
        case ($urandom_range(0, 7))
            0:       return 48'h0000_0000_0000;
            1:       return 48'hFFFF_FFFF_FFFF;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // Type value with a bias towards the table, the length boundary and the tag type.
    function automatic logic [15:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return KNOWN_ETHERTYPES[$urandom_range(0, TABLE_SIZE - 1)];
            4:          return 16'($urandom_range(0, LENGTH_LIMIT - 1));
            5:          return LENGTH_LIMIT - 16'($urandom_range(0, 1));
            6:          return TAG_TYPE;
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
        end
    endtask

    // Sends one byte word, with bursts and gaps as the current sender mode dictates.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = 0;
        if (tx_mode != IDLE_NONE) begin
            if (burst_left <= 0) begin
                if (tx_mode == IDLE_LIGHT) begin
                    gap        = $urandom_range(0, 3);
                    burst_left = $urandom_range(1, 16);
                end else begin
                    gap        = $urandom_range(1, 30);
                    burst_left = $urandom_range(1, 4);
                end
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        parse_byte(value, last);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // Fills the frame buffer with a header: outer type, or tag type, tag and inner type.
    task automatic make_header(input logic [47:0] dst, input logic [47:0] src,
                               input logic with_tag, input logic [15:0] tag,
                               input logic [15:0] value);
        frame_q.delete();
        for (int i = 5; i >= 0; i--) frame_q.push_back(dst[8*i +: 8]);
        for (int i = 5; i >= 0; i--) frame_q.push_back(src[8*i +: 8]);
        if (with_tag) begin
            frame_q.push_back(TAG_TYPE[15:8]);
            frame_q.push_back(TAG_TYPE[7:0]);
            frame_q.push_back(tag[15:8]);
            frame_q.push_back(tag[7:0]);
        end
        frame_q.push_back(value[15:8]);
        frame_q.push_back(value[7:0]);
    endtask

    task automatic add_payload(input int count);
        repeat (count) frame_q.push_back(8'($urandom));
    endtask

    task automatic cut_frame(input int keep);
        while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
    endtask

    // Every table entry once, plain and tagged in turn, with extreme addresses and tags.
    task automatic test_ethertype_table();
        logic [47:0] mac;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            mac = (i == 0) ? 48'h0 : (i == 1) ? 48'hFFFF_FFFF_FFFF : rand_mac();
            make_header(mac, (i == 0) ? 48'h0 : ~mac, i[0],
                        (i == 1) ? 16'h0000 : (i == 3) ? 16'hFFFF : 16'($urandom),
                        KNOWN_ETHERTYPES[i]);
            // Some headers end on the last byte of the packet.
            add_payload(i % 3);
            send_frame();
        end
    endtask

    // Values either side of the length limit, including a tagged frame right at the limit.
    task automatic test_length_frames();
        make_header(rand_mac(), rand_mac(), 1'b0, 16'h0, 16'h0000);
        add_payload(2);
        send_frame();
        make_header(rand_mac(), rand_mac(), 1'b0, 16'h0, LENGTH_LIMIT - 16'd1);
        send_frame();
        make_header(rand_mac(), rand_mac(), 1'b1, 16'h0FFF, LENGTH_LIMIT);
        add_payload(1);
        send_frame();
        make_header(rand_mac(), rand_mac(), 1'b0, 16'h0, 16'hFFFF);
        add_payload(4);
        send_frame();
    endtask

    // Packets that end before their header is complete.
    task automatic test_short_packets();
        int keep[4];
        keep = '{1, 13, 14, 17};
        foreach (keep[i]) begin
            make_header(rand_mac(), rand_mac(), i >= 2, 16'($urandom), pick_type());
            cut_frame(keep[i]);
            send_frame();
        end
    endtask

    // Mostly well-formed frames with random content, some truncated, some noise.
    task automatic test_random_frames(input int quota);
        int start;
        int frames;
        int kind;
        start  = sent_bytes;
        frames = 0;
        while (sent_bytes - start < quota) begin
            if (frames % 8 == 0) begin
                tx_mode = t_idle_mode'($urandom_range(0, 2));
                rx_mode = t_idle_mode'($urandom_range(0, 2));
            end
            kind = $urandom_range(0, 19);
            make_header(rand_mac(), rand_mac(), $urandom_range(0, 2) == 0,
                        16'($urandom), pick_type());
            if (kind == 0) begin
                add_payload($urandom_range(0, 40));
            end else if (kind < 14) begin
                add_payload($urandom_range(0, 6));
            end else if (kind < 17) begin
                cut_frame($urandom_range(1, frame_q.size() - 1));
            end else begin
                frame_q.delete();
                add_payload($urandom_range(1, 24));
            end
            send_frame();
            frames++;
        end
    endtask

    // Receiver: its own ready pattern, and a check of every accepted result word.
    always @(posedge i_clk) begin : rx_side
        t_hdr_result got;
        t_hdr_result want;
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            case (rx_mode)
                IDLE_NONE: begin
                    i_m_tready <= 1'b1;
                    rx_hold = 0;
                end
                IDLE_LIGHT: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                    rx_hold = $urandom_range(0, 5);
                end
                default: begin
                    // In this mode a long stall always ends with ready raised again.
                    if (!i_m_tready || $urandom_range(0, 3) == 0) begin
                        i_m_tready <= 1'b1;
                        rx_hold = $urandom_range(0, 2);
                    end else begin
                        i_m_tready <= 1'b0;
                        rx_hold = $urandom_range(5, 40);
                    end
                end
            endcase
        end

        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.dst_mac   = o_m_tdata[47:0];
            got.src_mac   = o_m_tdata[95:48];
            got.has_vlan  = o_m_tdata[96];
            got.vlan_tag  = o_m_tdata[112:97];
            got.type_len  = o_m_tdata[128:113];
            got.is_length = o_m_tdata[129];
            got.type_code = o_m_tdata[134:130];
            got.hdr_len   = o_m_tdata[139:135];
            got.too_short = o_m_tuser[0];
            if (hdr_expect.size() == 0) begin
                flag_mismatch("unexpected result (dst_mac)", 48'h0, got.dst_mac);
            end else begin
                want = hdr_expect.pop_front();
                if (got.dst_mac !== want.dst_mac)
                    flag_mismatch("dst_mac", want.dst_mac, got.dst_mac);
                if (got.src_mac !== want.src_mac)
                    flag_mismatch("src_mac", want.src_mac, got.src_mac);
                if (got.has_vlan !== want.has_vlan)
                    flag_mismatch("has_vlan", 48'(want.has_vlan), 48'(got.has_vlan));
                if (got.vlan_tag !== want.vlan_tag)
                    flag_mismatch("vlan_tag", 48'(want.vlan_tag), 48'(got.vlan_tag));
                if (got.type_len !== want.type_len)
                    flag_mismatch("type_or_length", 48'(want.type_len), 48'(got.type_len));
                if (got.is_length !== want.is_length)
                    flag_mismatch("is_length", 48'(want.is_length), 48'(got.is_length));
                if (got.type_code !== want.type_code)
                    flag_mismatch("type_code", 48'(want.type_code), 48'(got.type_code));
                if (got.hdr_len !== want.hdr_len)
                    flag_mismatch("header_length", 48'(want.hdr_len), 48'(got.hdr_len));
                if (got.too_short !== want.too_short)
                    flag_mismatch("too_short", 48'(want.too_short), 48'(got.too_short));
            end
            if (o_m_tdata[143:140] !== 4'h0)
                flag_mismatch("padding bits", 48'h0, 48'(o_m_tdata[143:140]));
        end
    end

    // Watchdog: too long without any accepted word on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tlast  <= 1'b0;
        clear_parse_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ethertype_table();
        test_length_frames();
        test_short_packets();
        // Random frames make up the rest of about 1300 bytes in all.
        test_random_frames(1300 - sent_bytes);

        i_s_tvalid <= 1'b0;
        while (hdr_expect.size() != 0) @(posedge i_clk);
        // Let any stray word from the pipeline show up before judging.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && hdr_expect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
